// ----- design/redp_pkg.sv -----
package redp_pkg;

   localparam int HeaderLen = 56;
   localparam int QueueDepthDefault = 4;

   // status codes
   localparam logic [2:0] StOk         = 3'd0;
   localparam logic [2:0] StBadMagic   = 3'd1;
   localparam logic [2:0] StBadVersion = 3'd2;
   localparam logic [2:0] StTruncated  = 3'd3;
   localparam logic [2:0] StOverrun    = 3'd4;

   // deframer phases
   localparam logic [1:0] PhPrefix = 2'd0;
   localparam logic [1:0] PhBody   = 2'd1;

   // register indexes
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrIndexWidth-1:0] CsrLengthPrefixed  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrExpectedMagic   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrExpectedVersion = 2'd2;

   localparam logic        LengthPrefixedReset  = 1'b1;
   localparam logic [31:0] ExpectedMagicReset   = 32'h4C52_4247;
   localparam logic [15:0] ExpectedVersionReset = 16'd1;

   typedef struct packed {
      logic [15:0] msg_type;
      logic [31:0] app_number;
      logic [63:0] source_ident;
      logic [63:0] dest_ident;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [63:0] sess_token;
   } hdr_type;

   // one queue entry: what one accepted byte produces
   typedef struct packed {
      logic        has_pay;
      logic [7:0]  pay_byte;
      logic        has_end;
      logic [2:0]  status;
      hdr_type     hdr;
      logic [31:0] payload_length;
   } cmd_type;

   typedef struct packed {
      logic        frame_end;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      hdr_type     hdr;
      logic [31:0] payload_length;
   } result_type;

endpackage

// ----- design/relay_envelope_deframer_parser_top.sv -----
// latency: a result can be transferred in the cycle after the byte that causes it
// throughput: one byte per cycle while req_full is low; a byte with a payload item and a frame end item
//   takes two output transfers, absorbed by the entry queue between parser and output
// reset: synchronous, active high; empties the queue, restarts the deframer at
//   frame start and returns the registers to their default values
module relay_envelope_deframer_parser_top #(
   parameter int QueueDepth = redp_pkg::QueueDepthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_data,
   input  logic                                req_datagram_end,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_frame_end,
   output logic [7:0]                          rsp_payload_byte,
   output logic [2:0]                          rsp_status,
   output logic [15:0]                         rsp_msg_type,
   output logic [31:0]                         rsp_app_number,
   output logic [63:0]                         rsp_source_ident,
   output logic [63:0]                         rsp_dest_ident,
   output logic [31:0]                         rsp_source_ip,
   output logic [15:0]                         rsp_source_port,
   output logic [63:0]                         rsp_sess_token,
   output logic [31:0]                         rsp_payload_length,
   input  logic                                csr_we,
   input  logic [redp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [redp_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import redp_pkg::*;

   logic       accept;
   logic       cmd_valid;
   cmd_type    cmd;
   cmd_type    head;
   logic       q_empty;
   logic       q_pop;
   result_type result;

   assign accept = req_push && !req_full;

   // parser front end
   redp_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .data(req_data),
      .datagram_end(req_datagram_end),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd_valid(cmd_valid),
      .cmd(cmd)
   );

   // entry queue
   redp_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_valid),
      .push_cmd(cmd),
      .pop(q_pop),
      .full(req_full),
      .empty(q_empty),
      .head(head)
   );

   // output side
   redp_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .q_empty(q_empty),
      .rsp_pop(rsp_pop),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .result(result)
   );

   assign rsp_frame_end = result.frame_end;
   assign rsp_payload_byte = result.payload_byte;
   assign rsp_status = result.status;
   assign rsp_msg_type = result.hdr.msg_type;
   assign rsp_app_number = result.hdr.app_number;
   assign rsp_source_ident = result.hdr.source_ident;
   assign rsp_dest_ident = result.hdr.dest_ident;
   assign rsp_source_ip = result.hdr.source_ip;
   assign rsp_source_port = result.hdr.source_port;
   assign rsp_sess_token = result.hdr.sess_token;
   assign rsp_payload_length = result.payload_length;

endmodule

// ----- design/redp_front.sv -----
module redp_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [7:0]                           data,
   input  logic                                 datagram_end,
   input  logic                                 csr_we,
   input  logic [redp_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [redp_pkg::CsrDataWidth-1:0]    csr_wdata,
   output logic                                 cmd_valid,
   output redp_pkg::cmd_type                    cmd
);
   import redp_pkg::*;

   logic        lp_ff, lp_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] version_ff, version_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] flen_ff, flen_in;
   logic [31:0] shift_ff, shift_in;
   hdr_type     hdr_ff, hdr_in;
   logic [2:0]  err_ff, err_in;

   logic [1:0]  k;
   logic [5:0]  p6;
   logic [5:0]  off;
   logic        in_hdr;
   logic        end_now;
   logic [31:0] plen;
   logic [31:0] pay_idx;
   logic [31:0] body_cnt;

   // parse one byte and build the queue entry
   always_comb begin
      lp_in = lp_ff;
      magic_in = magic_ff;
      version_in = version_ff;
      phase_in = phase_ff;
      pos_in = pos_ff;
      flen_in = flen_ff;
      shift_in = shift_ff;
      hdr_in = hdr_ff;
      err_in = err_ff;
      cmd = '0;
      k = pos_ff[1:0];
      p6 = pos_ff[5:0];
      off = '0;
      in_hdr = (pos_ff[31:6] == '0) && (p6 < 6'(HeaderLen));
      end_now = 1'b0;
      plen = '0;
      pay_idx = pos_ff - 32'(HeaderLen);
      body_cnt = '0;
      if (accept) begin
         if (lp_ff && phase_ff == PhPrefix) begin
            // length prefix
            flen_in = ((k == 2'd0) ? 32'd0 : flen_ff) | ({24'd0, data} << {k, 3'b000});
            pos_in = {30'd0, k} + 32'd1;
            if (k == 2'd3) begin
               pos_in = '0;
               shift_in = '0;
               hdr_in = '0;
               err_in = StOk;
               phase_in = PhBody;
               if (flen_in == '0) begin
                  cmd.has_end = 1'b1;
                  cmd.status = StTruncated;
                  phase_in = PhPrefix;
               end
            end
         end else begin
            // frame byte
            if (in_hdr) begin
               priority if (p6 < 6'd4) begin
                  if (p6 == 6'd0) shift_in = '0;
                  shift_in[{p6[1:0], 3'b000} +: 8] = data;
                  if (p6 == 6'd3 && err_ff == StOk && shift_in != magic_ff)
                     err_in = StBadMagic;
               end else if (p6 < 6'd6) begin
                  off = p6 - 6'd4;
                  if (p6 == 6'd4) shift_in = '0;
                  shift_in[{off[1:0], 3'b000} +: 8] = data;
                  if (p6 == 6'd5 && err_ff == StOk && shift_in[15:0] != version_ff)
                     err_in = StBadVersion;
               end else if (p6 < 6'd8) begin
                  off = p6 - 6'd6;
                  hdr_in.msg_type[{off[0], 3'b000} +: 8] = data;
               end else if (p6 < 6'd12) begin
                  // flags not kept
               end else if (p6 < 6'd16) begin
                  off = p6 - 6'd12;
                  hdr_in.app_number[{off[1:0], 3'b000} +: 8] = data;
               end else if (p6 < 6'd24) begin
                  off = p6 - 6'd16;
                  hdr_in.source_ident[{off[2:0], 3'b000} +: 8] = data;
               end else if (p6 < 6'd32) begin
                  off = p6 - 6'd24;
                  hdr_in.dest_ident[{off[2:0], 3'b000} +: 8] = data;
               end else if (p6 < 6'd36) begin
                  off = p6 - 6'd32;
                  hdr_in.source_ip[{off[1:0], 3'b000} +: 8] = data;
               end else if (p6 < 6'd38) begin
                  off = p6 - 6'd36;
                  hdr_in.source_port[{off[0], 3'b000} +: 8] = data;
               end else if (p6 < 6'd44) begin
                  // destination endpoint not kept
               end else if (p6 < 6'd52) begin
                  off = p6 - 6'd44;
                  hdr_in.sess_token[{off[2:0], 3'b000} +: 8] = data;
               end else begin
                  off = p6 - 6'd52;
                  if (p6 == 6'd52) shift_in = '0;
                  shift_in[{off[1:0], 3'b000} +: 8] = data;
               end
            end else if (err_ff == StOk && pay_idx < shift_ff) begin
               cmd.has_pay = 1'b1;
               cmd.pay_byte = data;
            end
            pos_in = (&pos_ff) ? pos_ff : pos_ff + 32'd1;

            // frame end check on the updated state
            end_now = lp_ff ? (pos_in == flen_ff) : datagram_end;
            if (end_now) begin
               plen = (pos_in >= 32'd53) ? shift_in : 32'd0;
               body_cnt = pos_in - 32'(HeaderLen);
               cmd.has_end = 1'b1;
               cmd.hdr = hdr_in;
               cmd.payload_length = plen;
               priority if (err_in != StOk) cmd.status = err_in;
               else if (pos_in < 32'(HeaderLen)) cmd.status = StTruncated;
               else if (plen > body_cnt) cmd.status = StOverrun;
               else cmd.status = StOk;
               pos_in = '0;
               shift_in = '0;
               hdr_in = '0;
               err_in = StOk;
               phase_in = PhPrefix;
            end
         end
      end

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            CsrLengthPrefixed: begin
               lp_in = csr_wdata[0];
               phase_in = PhPrefix;
               flen_in = '0;
               pos_in = '0;
               shift_in = '0;
               hdr_in = '0;
               err_in = StOk;
            end
            CsrExpectedMagic: magic_in = csr_wdata[31:0];
            CsrExpectedVersion: version_in = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
      cmd_valid = accept && (cmd.has_pay || cmd.has_end);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff <= LengthPrefixedReset;
         magic_ff <= ExpectedMagicReset;
         version_ff <= ExpectedVersionReset;
         phase_ff <= PhPrefix;
         pos_ff <= '0;
         flen_ff <= '0;
         shift_ff <= '0;
         hdr_ff <= '0;
         err_ff <= StOk;
      end else begin
         lp_ff <= lp_in;
         magic_ff <= magic_in;
         version_ff <= version_in;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         flen_ff <= flen_in;
         shift_ff <= shift_in;
         hdr_ff <= hdr_in;
         err_ff <= err_in;
      end
   end

endmodule

// ----- design/redp_queue.sv -----
module redp_queue #(
   parameter int Depth = redp_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  redp_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output redp_pkg::cmd_type head
);
   import redp_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   cmd_type mem [Depth];
   logic [PtrWidth-1:0] wr_ff, wr_in;
   logic [PtrWidth-1:0] rd_ff, rd_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = (cnt_ff == CntWidth'(Depth));
   assign empty = (cnt_ff == '0);
   assign head = mem[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + PtrWidth'(1);
      if (do_pop) rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + PtrWidth'(1);
      if (do_push && !do_pop) cnt_in = cnt_ff + CntWidth'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CntWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_cmd;
   end

endmodule

// ----- design/redp_back.sv -----
module redp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  redp_pkg::cmd_type    head,
   input  logic                 q_empty,
   input  logic                 rsp_pop,
   output logic                 q_pop,
   output logic                 rsp_empty,
   output redp_pkg::result_type result
);
   import redp_pkg::*;

   // set once the payload byte of a head entry that also ends a frame has been transferred
   logic sub_ff, sub_in;
   logic show_pay;

   assign rsp_empty = q_empty;
   assign show_pay = head.has_pay && !sub_ff;

   // expand one entry into its result items
   always_comb begin
      result = '0;
      if (show_pay) begin
         result.payload_byte = head.pay_byte;
      end else begin
         result.frame_end = 1'b1;
         result.status = head.status;
         result.hdr = head.hdr;
         result.payload_length = head.payload_length;
      end
      q_pop = 1'b0;
      sub_in = sub_ff;
      if (rsp_pop && !q_empty) begin
         if (show_pay && head.has_end) begin
            sub_in = 1'b1;
         end else begin
            q_pop = 1'b1;
            sub_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

// ----- design/redp_checker.sv -----
module redp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_frame_end,
   input logic [7:0]  rsp_payload_byte,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_payload_length
);

   // reset leaves both sides empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue not empty after reset");

   // a waiting result holds until transferred
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_frame_end)
         && $stable(rsp_payload_byte))
      else $error("waiting result changed");

   // payload items carry no status or header length
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_frame_end |-> rsp_status == 3'd0 && rsp_payload_length == 32'd0)
      else $error("payload item carries frame end fields");

   // frame end items carry a defined status and no payload byte
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_frame_end |-> (rsp_status == 3'd0 || rsp_status == 3'd1
         || rsp_status == 3'd2 || rsp_status == 3'd3 || rsp_status == 3'd4)
         && rsp_payload_byte == 8'd0)
      else $error("bad frame end item");

endmodule

bind relay_envelope_deframer_parser_top redp_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_full(req_full),
   .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop),
   .rsp_frame_end(rsp_frame_end),
   .rsp_payload_byte(rsp_payload_byte),
   .rsp_status(rsp_status),
   .rsp_payload_length(rsp_payload_length)
);
